[rtl/wsro_pkg.sv]
// Package for the window raise block: payload structs, action codes, controller
// states, and the command/status structs between the controller and datapath.
// No dependencies.
package wsro_pkg;

  localparam int unsigned SlotBits = 4;
  localparam int unsigned NumSlots = 16;
  localparam int unsigned MaskBits = 16;
  localparam int unsigned MaxCap   = 15;

  typedef enum logic [1:0] {
    ActPop  = 2'd0,
    ActPush = 2'd1,
    ActDone = 2'd2
  } action_e;

  typedef struct packed {
    logic [7:0] window_id;
    logic [7:0] left_col;
    logic [7:0] top_row;
    logic [7:0] win_width;
    logic [7:0] win_height;
    logic       has_shadow;
  } req_t;

  typedef struct packed {
    logic [1:0]  action;
    logic [3:0]  slot;
    logic        status;
    logic [15:0] top_mask;
    logic [3:0]  top_index;
    logic        last;
  } rsp_t;

  typedef enum logic [3:0] {
    StIdle,
    StSearch,
    StMark,
    StSelect,
    StPop,
    StPush,
    StPushW,
    StShift,
    StPlace,
    StOvl,
    StDone
  } state_e;

  typedef struct packed {
    logic       load;       // capture request, start scan at top
    logic       step_down;  // search: move index down
    logic       mark_step;  // mark: test overlap, move index up
    logic       mark_init;  // set index to w+1 and list to w
    logic       pop_init;   // index to top
    logic       pop_step;   // index down
    logic       push_init;  // index to w+1
    logic       push_step;  // index up
    logic       push_w;     // slot output shows w
    logic       shift_init; // index to w
    logic       shift_step; // move i+1 into i, index up
    logic       place;      // write saved window at top
    logic       new_win;    // push new window at top+1
    logic       ovl_init;   // start overlap compute of top
    logic       ovl_step;
    logic       ovl_write;
  } cmd_t;

  typedef struct packed {
    logic       found;      // current index matches id
    logic       idx_zero;   // search index reached 0
    logic       is_top;     // index equals top
    logic       idx_lt_w;   // pop index below w
    logic       in_list;    // index is in list
    logic       list_only_w;
    logic       full;
    logic       ovl_end;    // overlap scan finished
  } sts_t;

endpackage

[rtl/wsro_dp.sv]
// Datapath for the window raise block: stack registers, scan index, list mask,
// overlap unit. Depends on wsro_pkg.
module wsro_dp #(
  parameter int unsigned Cap       = 15,
  parameter int unsigned IdBits    = 8,
  parameter int unsigned CoordBits = 8
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  wsro_pkg::req_t  req_i,
  input  wsro_pkg::cmd_t  cmd_i,
  output wsro_pkg::sts_t  sts_o,
  output logic [3:0]      idx_o,
  output logic [15:0]     top_mask_o,
  output logic [3:0]      top_o
);
  import wsro_pkg::*;

  typedef struct packed {
    logic [CoordBits-1:0] l;
    logic [CoordBits-1:0] t;
    logic [CoordBits-1:0] w;
    logic [CoordBits-1:0] h;
    logic                 s;
  } rect_t;

  logic [IdBits-1:0]   id_q   [NumSlots];
  rect_t               rect_q [NumSlots];
  logic [MaskBits-1:0] ovl_q  [NumSlots];
  logic [3:0]          top_q, idx_q, w_q;
  logic [MaskBits-1:0] list_q, acc_q;
  logic [IdBits-1:0]   rid_q;
  rect_t               rr_q;

  logic [IdBits-1:0] req_id;
  rect_t             req_rect;
  assign req_id   = IdBits'(req_i.window_id);
  assign req_rect = '{l: CoordBits'(req_i.left_col), t: CoordBits'(req_i.top_row),
                      w: CoordBits'(req_i.win_width), h: CoordBits'(req_i.win_height),
                      s: req_i.has_shadow};

  // edges as signed values, two spare bits
  localparam int unsigned EB = CoordBits + 2;
  function automatic logic signed [EB-1:0] redge(rect_t r);
    redge = $signed({2'b00, r.l}) + $signed({2'b00, r.w}) + (r.s ? EB'(1) : -EB'(1));
  endfunction
  function automatic logic signed [EB-1:0] bedge(rect_t r);
    bedge = $signed({2'b00, r.t}) + $signed({2'b00, r.h}) + (r.s ? EB'(0) : -EB'(1));
  endfunction

  rect_t a, b;
  logic  apart;
  assign a = rect_q[top_q];
  assign b = rect_q[idx_q];
  assign apart = ($signed({2'b00, a.l}) > redge(b)) || ($signed({2'b00, a.t}) > bedge(b)) ||
                 ($signed({2'b00, b.l}) > redge(a)) || ($signed({2'b00, b.t}) > bedge(a));

  logic [MaskBits-1:0] low;
  assign low = (MaskBits'(1) << w_q) - MaskBits'(1);

  logic found_w;
  assign found_w = (idx_q != '0) && (id_q[idx_q] == rid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      top_q <= '0;
      ovl_q <= '{0: MaskBits'(1), default: '0};
    end else begin
      if (cmd_i.new_win) begin
        top_q <= top_q + 4'd1;
      end
      if (cmd_i.shift_step) begin
        ovl_q[idx_q] <= (ovl_q[idx_q + 4'd1] & low) | ((ovl_q[idx_q + 4'd1] >> 1) & ~low);
      end
      if (cmd_i.ovl_write) ovl_q[top_q] <= acc_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      rid_q <= req_id;
      rr_q  <= req_rect;
      idx_q <= top_q;
    end
    if (cmd_i.step_down) begin
      if (found_w) begin
        w_q    <= idx_q;
        rr_q   <= rect_q[idx_q];
      end else begin
        idx_q <= idx_q - 4'd1;
      end
    end
    // w is found at the current index in this same cycle
    if (cmd_i.mark_init) begin
      idx_q  <= idx_q + 4'd1;
      list_q <= MaskBits'(1) << idx_q;
    end
    if (cmd_i.mark_step) begin
      if ((list_q & ovl_q[idx_q]) != '0) list_q <= list_q | (MaskBits'(1) << idx_q);
      idx_q <= idx_q + 4'd1;
    end
    if (cmd_i.pop_init)  idx_q <= top_q;
    if (cmd_i.pop_step)  idx_q <= idx_q - 4'd1;
    if (cmd_i.push_init) idx_q <= w_q + 4'd1;
    if (cmd_i.push_step) idx_q <= idx_q + 4'd1;
    if (cmd_i.shift_init) idx_q <= w_q;
    if (cmd_i.shift_step) begin
      id_q[idx_q]   <= id_q[idx_q + 4'd1];
      rect_q[idx_q] <= rect_q[idx_q + 4'd1];
      idx_q <= idx_q + 4'd1;
    end
    if (cmd_i.place) begin
      id_q[top_q]   <= rid_q;
      rect_q[top_q] <= rr_q;
    end
    if (cmd_i.new_win) begin
      id_q[top_q + 4'd1]   <= rid_q;
      rect_q[top_q + 4'd1] <= rr_q;
    end
    if (cmd_i.ovl_init) begin
      idx_q <= 4'd1;
      acc_q <= MaskBits'(1);
    end
    if (cmd_i.ovl_step) begin
      if (!apart) acc_q <= acc_q | (MaskBits'(1) << idx_q);
      idx_q <= idx_q + 4'd1;
    end
  end

  assign sts_o.found       = found_w;
  assign sts_o.idx_zero    = (idx_q == '0);
  assign sts_o.is_top      = (idx_q == top_q);
  assign sts_o.idx_lt_w    = (idx_q < w_q);
  assign sts_o.in_list     = list_q[idx_q];
  assign sts_o.list_only_w = (list_q == (MaskBits'(1) << w_q));
  assign sts_o.full        = (top_q >= 4'(Cap));
  assign sts_o.ovl_end     = (idx_q >= top_q);

  assign idx_o      = cmd_i.push_w ? w_q : idx_q;
  assign top_mask_o = ovl_q[top_q];
  assign top_o      = top_q;

endmodule

[rtl/wsro_ctrl.sv]
// Controller for the window raise block: sequences the datapath and drives the
// result channel. Depends on wsro_pkg.
module wsro_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output wsro_pkg::rsp_t out_data_o,
  input  wsro_pkg::sts_t sts_i,
  input  logic [3:0]     idx_i,
  input  logic [15:0]    top_mask_i,
  input  logic [3:0]     top_i,
  output wsro_pkg::cmd_t cmd_o
);
  import wsro_pkg::*;

  state_e state_q, state_d;
  logic   ovl_last_q; // overlap pass started
  logic   lim_q;      // new window refused, stack full
  logic   vld_q;
  rsp_t   rsp_q;
  logic   emit;
  rsp_t   emit_rsp;
  logic   free;

  assign free = !vld_q || out_ready_i;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StIdle:   if (in_valid_i) state_d = StSearch;
      StSearch: begin
        if (sts_i.idx_zero) begin
          state_d = sts_i.full ? StDone : StOvl;
        end else if (sts_i.found) begin
          state_d = sts_i.is_top ? StDone : StMark;
        end
      end
      StMark:   if (sts_i.is_top) state_d = StSelect;
      StSelect: state_d = sts_i.list_only_w ? StShift : StPop;
      StPop:    if (free && sts_i.idx_lt_w) state_d = StPush;
      StPush:   if (free && sts_i.is_top) state_d = StPushW;
      StPushW:  if (free) state_d = StShift;
      StShift:  if (sts_i.is_top) state_d = StPlace;
      StPlace:  state_d = StOvl;
      StOvl:    if (ovl_last_q && sts_i.ovl_end) state_d = StDone;
      StDone:   if (free) state_d = StIdle;
      default:  state_d = StIdle;
    endcase
  end

  always_comb begin
    cmd_o    = '0;
    emit     = 1'b0;
    emit_rsp = '0;
    unique case (state_q)
      StIdle:   cmd_o.load = in_valid_i;
      StSearch: begin
        if (!sts_i.idx_zero) cmd_o.step_down = 1'b1;
        if (!sts_i.idx_zero && sts_i.found && !sts_i.is_top) cmd_o.mark_init = 1'b1;
        if (sts_i.idx_zero && !sts_i.full) begin
          cmd_o.new_win  = 1'b1;
        end
      end
      StMark:   cmd_o.mark_step = 1'b1;
      StSelect: begin
        if (sts_i.list_only_w) cmd_o.shift_init = 1'b1;
        else cmd_o.pop_init = 1'b1;
      end
      StPop: begin
        if (free) begin
          if (sts_i.idx_lt_w) cmd_o.push_init = 1'b1;
          else begin
            cmd_o.pop_step = 1'b1;
            if (sts_i.in_list) begin
              emit = 1'b1;
              emit_rsp = '{action: ActPop, slot: idx_i, default: '0};
            end
          end
        end
      end
      StPush: begin
        if (free) begin
          if (!sts_i.is_top) cmd_o.push_step = 1'b1;
          if (sts_i.in_list) begin
            emit = 1'b1;
            emit_rsp = '{action: ActPush, slot: idx_i, default: '0};
          end
        end
      end
      StPushW: begin
        cmd_o.push_w = 1'b1;
        if (free) begin
          cmd_o.shift_init = 1'b1;
          emit = 1'b1;
          emit_rsp = '{action: ActPush, slot: idx_i, default: '0};
        end
      end
      StShift: begin
        if (sts_i.is_top) cmd_o.place = 1'b1;
        else cmd_o.shift_step = 1'b1;
      end
      StPlace:  cmd_o.ovl_init = 1'b1;
      StOvl: begin
        if (!ovl_last_q) cmd_o.ovl_init = 1'b1;
        else if (sts_i.ovl_end) cmd_o.ovl_write = 1'b1;
        else cmd_o.ovl_step = 1'b1;
      end
      StDone: begin
        if (free) begin
          emit = 1'b1;
          emit_rsp = '{action: ActDone, slot: '0, status: lim_q,
                       top_mask: top_mask_i, top_index: top_i, last: 1'b1};
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= StIdle;
      vld_q      <= 1'b0;
      ovl_last_q <= 1'b0;
      lim_q      <= 1'b0;
    end else begin
      state_q <= state_d;
      if (emit) vld_q <= 1'b1;
      else if (out_ready_i) vld_q <= 1'b0;
      if (state_q == StIdle) ovl_last_q <= 1'b0;
      else if (state_q == StOvl || state_q == StPlace) ovl_last_q <= 1'b1;
      if (state_q == StIdle) lim_q <= 1'b0;
      else if (state_q == StSearch && sts_i.idx_zero && sts_i.full) lim_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) rsp_q <= emit_rsp;
  end

  assign in_ready_o  = (state_q == StIdle);
  assign out_valid_o = vld_q;
  assign out_data_o  = rsp_q;

endmodule

[rtl/window_stack_raise_overlap.sv]
// Window raise block with a z-ordered overlap stack.
// One request at a time, set by the slot walks of the controller over the stack
// registers. Result items leave through one output register, at most one per cycle.
// Reset: asynchronous active low, stack empty (base layer only).
module window_stack_raise_overlap #(
  parameter int unsigned MAX_WINDOWS = 15,
  parameter int unsigned ID_BITS     = 8,
  parameter int unsigned COORD_BITS  = 8
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  wsro_pkg::req_t in_data_i,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output wsro_pkg::rsp_t out_data_o
);
  import wsro_pkg::*;

  localparam int unsigned Cap = (MAX_WINDOWS > MaxCap) ? MaxCap : MAX_WINDOWS;

  cmd_t        cmd;
  sts_t        sts;
  logic [3:0]  idx, top;
  logic [15:0] top_mask;

  wsro_dp #(.Cap(Cap), .IdBits(ID_BITS), .CoordBits(COORD_BITS)) u_dp (
    .clk_i, .rst_ni, .req_i(in_data_i), .cmd_i(cmd), .sts_o(sts),
    .idx_o(idx), .top_mask_o(top_mask), .top_o(top)
  );

  wsro_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .out_valid_o, .out_ready_i,
    .out_data_o, .sts_i(sts), .idx_i(idx), .top_mask_i(top_mask), .top_i(top),
    .cmd_o(cmd)
  );

`ifndef SYNTHESIS
  a_done_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_data_o.last == (out_data_o.action == ActDone))) else $error("last");
  a_top_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    top <= 4'(Cap)) else $error("top over capacity");
  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o) else $error("accept while busy");
`endif

endmodule
